### rtl/pid_pkg.sv
// Shared types, constants and saturation helper for the PID controller step block.
package pid_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIM   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_LIM     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD      = 3'd6;

  // Reset value of the sample period: 1.0 in Q16.16.
  localparam logic [30:0] PERIOD_RESET = 31'd65536;

  // Quotient bits produced one per cycle by the divider.
  localparam int unsigned DIV_STEPS = 31;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Status of the rate divider as seen by the sequencer.
  typedef struct packed {
    logic               done;
    logic signed [31:0] quot;
  } div_stat_t;

  // Saturate a wide signed value to signed 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [31:0] res;
    if (v > 49'sd2147483647) begin
      res = S32_MAX;
    end else if (v < -49'sd2147483648) begin
      res = S32_MIN;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

### rtl/pid_mul.sv
// Shared registered 32x32 signed multiplier returning the product floored by 2^16.
module pid_mul
  import pid_pkg::*;
(
  input  logic               clk,
  input  logic signed [31:0] op_a,
  input  logic signed [31:0] op_b,
  output logic signed [47:0] prod_q   // floor(op_a * op_b / 65536), registered
);

  logic signed [63:0] prod_r;

  // Exact product; the arithmetic drop of 16 bits rounds toward minus infinity.
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod_q = prod_r[63:16];

endmodule

### rtl/pid_div.sv
// Iterative restoring divider for the measurement rate: (diff * 65536) / period.
module pid_div
  import pid_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [32:0] diff,     // measurement change, 33-bit signed
  input  logic [30:0]        period,   // divisor, zero treated as one
  output div_stat_t          stat
);

  typedef enum logic [1:0] {D_IDLE, D_PREP, D_RUN, D_FIN} dstate_t;

  dstate_t     dstate_r;
  logic        done_r;
  logic        neg_r;
  logic        ovf_r;
  logic [32:0] mag_r;
  logic [30:0] dsr_r;
  logic [30:0] rem_r;
  logic [30:0] low_r;
  logic [30:0] quo_r;
  logic [4:0]  cnt_r;
  logic signed [31:0] quot_r;

  logic [17:0] hi;
  logic [31:0] trial;
  logic [31:0] trial_sub;
  logic        take;

  // Upper dividend bits above the quotient range, and one restoring step.
  assign hi        = mag_r[32:15];
  assign trial     = {rem_r, low_r[30]};
  assign trial_sub = trial - {1'b0, dsr_r};
  assign take      = trial >= {1'b0, dsr_r};

  // Sequencer of the divider and its registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dstate_r <= D_IDLE;
      done_r   <= 1'b0;
    end else begin
      case (dstate_r)
        D_IDLE: begin
          if (start) begin
            done_r   <= 1'b0;
            neg_r    <= diff[32];
            mag_r    <= diff[32] ? 33'(-diff) : 33'(diff);
            dsr_r    <= (period == '0) ? 31'd1 : period;
            dstate_r <= D_PREP;
          end
        end
        D_PREP: begin
          // A quotient of 2^31 or more saturates without iterating.
          ovf_r    <= {13'd0, hi} >= dsr_r;
          rem_r    <= {13'd0, hi};
          low_r    <= {mag_r[14:0], 16'd0};
          quo_r    <= '0;
          cnt_r    <= '0;
          dstate_r <= ({13'd0, hi} >= dsr_r) ? D_FIN : D_RUN;
        end
        D_RUN: begin
          rem_r <= take ? trial_sub[30:0] : trial[30:0];
          low_r <= {low_r[29:0], 1'b0};
          quo_r <= {quo_r[29:0], take};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(DIV_STEPS - 1)) begin
            dstate_r <= D_FIN;
          end
        end
        D_FIN: begin
          if (ovf_r) begin
            quot_r <= neg_r ? S32_MIN : S32_MAX;
          end else begin
            quot_r <= neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
          end
          done_r   <= 1'b1;
          dstate_r <= D_IDLE;
        end
        default: dstate_r <= D_IDLE;
      endcase
    end
  end

  assign stat.done = done_r;
  assign stat.quot = quot_r;

endmodule

### rtl/pid_controller_step_top.sv
// Top level of the PID controller step: configuration, sequencer and output register.
//
// One beat on the input stream (setpoint and measurement, signed Q16.16) yields one
// beat on the output stream carrying the clamped drive value and a clamp flag. The
// block handles one item at a time. The time per item is set by the rate divider: a
// set-up step, 31 quotient bits one per cycle and a finishing step, while the single
// shared multiplier forms the proportional, integral-increment and integral products
// in the shadow of the division. When the rate saturates the quotient steps are
// skipped. A finished result waits in the output register, so the next beat can be
// accepted before it is taken; a result that is still waiting when the next one is
// ready holds the sequencer in its last state. Registers are to be written through
// the configuration port only while the block is idle; the block itself does not
// enforce this. Index 7 is ignored.
module pid_controller_step_top
  import pid_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  // Input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [63:0]          in_tdata,   // [31:0] target_value, [63:32] measured_value
  // Result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // [31:0] drive_value
  output logic [0:0]           out_tuser   // [0] drive_clamped
);

  typedef enum logic [3:0] {
    S_IDLE, S_ERR, S_DB, S_MP, S_MI, S_INC, S_ACC, S_LIM,
    S_MII, S_IT, S_WDIV, S_DT, S_ADD, S_OUT
  } state_t;

  // Configuration registers.
  logic signed [31:0] gain_p_r;
  logic signed [31:0] gain_i_r;
  logic signed [31:0] gain_d_r;
  logic [30:0]        drive_lim_r;
  logic [30:0]        acc_lim_r;
  logic [30:0]        dead_band_r;
  logic [30:0]        period_r;

  // Controller state and working registers.
  state_t             state_r;
  logic signed [31:0] acc_r;
  logic signed [31:0] last_r;
  logic signed [31:0] target_r;
  logic signed [31:0] meas_r;
  logic signed [31:0] error_r;
  logic signed [32:0] diff_r;
  logic signed [31:0] tmp_r;
  logic signed [33:0] sum_r;
  logic               out_valid_r;
  logic [31:0]        drive_r;
  logic               clamped_r;

  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [47:0] prod_q;
  logic signed [31:0] prod_sat;
  logic signed [31:0] prod_neg_sat;
  logic               div_start;
  div_stat_t          div_stat;
  logic [32:0]        err_mag;
  logic signed [31:0] acc_lim_s;
  logic signed [33:0] drive_lim_s;
  logic               out_free;
  logic               out_load;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);

  // Register writes; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      drive_lim_r <= '0;
      acc_lim_r   <= '0;
      dead_band_r <= '0;
      period_r    <= PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GAIN_P:    gain_p_r    <= cfg_data;
        REG_GAIN_I:    gain_i_r    <= cfg_data;
        REG_GAIN_D:    gain_d_r    <= cfg_data;
        REG_DRIVE_LIM: drive_lim_r <= cfg_data[30:0];
        REG_ACC_LIM:   acc_lim_r   <= cfg_data[30:0];
        REG_DEAD_BAND: dead_band_r <= cfg_data[30:0];
        REG_PERIOD:    period_r    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MP: begin
        mul_a = gain_p_r;
        mul_b = error_r;
      end
      S_MI: begin
        mul_a = error_r;
        mul_b = $signed({1'b0, period_r});
      end
      S_MII: begin
        mul_a = gain_i_r;
        mul_b = acc_r;
      end
      S_WDIV: begin
        mul_a = gain_d_r;
        mul_b = div_stat.quot;
      end
      default: ;
    endcase
  end

  pid_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_q (prod_q)
  );

  assign div_start = (state_r == S_DB);

  pid_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .diff   (diff_r),
    .period (period_r),
    .stat   (div_stat)
  );

  // Saturated product, plain and negated, and the limits in signed form.
  assign prod_sat     = sat32(49'(prod_q));
  assign prod_neg_sat = sat32(-49'(prod_q));
  assign err_mag      = error_r[31] ? 33'(-33'(error_r)) : 33'(33'(error_r));
  assign acc_lim_s    = $signed({1'b0, acc_lim_r});
  assign drive_lim_s  = $signed({3'b000, drive_lim_r});
  assign out_free     = !out_valid_r || out_tready;
  assign out_load     = (state_r == S_OUT) && out_free;

  // Sequencer, datapath registers and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_tready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            target_r <= in_tdata[31:0];
            meas_r   <= in_tdata[63:32];
            state_r  <= S_ERR;
          end
        end
        S_ERR: begin
          error_r <= sat32(49'(target_r) - 49'(meas_r));
          diff_r  <= 33'(meas_r) - 33'(last_r);
          last_r  <= meas_r;
          state_r <= S_DB;
        end
        S_DB: begin
          // Dead band: errors strictly smaller in magnitude count as zero.
          if (err_mag < {2'b00, dead_band_r}) begin
            error_r <= '0;
          end
          state_r <= S_MP;
        end
        S_MP: begin
          state_r <= S_MI;
        end
        S_MI: begin
          sum_r   <= 34'(prod_sat);
          state_r <= S_INC;
        end
        S_INC: begin
          tmp_r   <= prod_sat;
          state_r <= S_ACC;
        end
        S_ACC: begin
          tmp_r   <= sat32(49'(acc_r) + 49'(tmp_r));
          state_r <= S_LIM;
        end
        S_LIM: begin
          // Anti-windup clamp on the integral.
          if (tmp_r > acc_lim_s) begin
            acc_r <= acc_lim_s;
          end else if (tmp_r < -acc_lim_s) begin
            acc_r <= -acc_lim_s;
          end else begin
            acc_r <= tmp_r;
          end
          state_r <= S_MII;
        end
        S_MII: begin
          state_r <= S_IT;
        end
        S_IT: begin
          sum_r   <= sum_r + 34'(prod_sat);
          state_r <= S_WDIV;
        end
        S_WDIV: begin
          if (div_stat.done) begin
            state_r <= S_DT;
          end
        end
        S_DT: begin
          tmp_r   <= prod_neg_sat;
          state_r <= S_ADD;
        end
        S_ADD: begin
          sum_r   <= sum_r + 34'(tmp_r);
          state_r <= S_OUT;
        end
        S_OUT: begin
          // Output clamp; a sum exactly at the limit is not flagged.
          if (out_free) begin
            if (sum_r > drive_lim_s) begin
              drive_r   <= drive_lim_s[31:0];
              clamped_r <= 1'b1;
            end else if (sum_r < -drive_lim_s) begin
              drive_r   <= 32'(-drive_lim_s);
              clamped_r <= 1'b1;
            end else begin
              drive_r   <= sum_r[31:0];
              clamped_r <= 1'b0;
            end
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = drive_r;
  assign out_tuser[0] = clamped_r;

endmodule

### tb/tb_pid_controller_step_top.sv
// Self-checking testbench for the PID controller step block, with its scoreboard class.
module tb_pid_controller_step_top
  import pid_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Index beyond the register file; a write to it must leave every setting alone.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               clamped;
  } drive_beat_t;

  // Predicts the drive value of each setpoint beat and checks the result beats in order.
  class drive_scoreboard;
    longint gain_p, gain_i, gain_d;
    longint drive_lim, acc_lim, band_thresh, period;
    longint integral_acc, prev_measured;
    drive_beat_t expected_drives[$];
    int unsigned failures;

    function new();
      gain_p = 0;
      gain_i = 0;
      gain_d = 0;
      drive_lim = 0;
      acc_lim = 0;
      band_thresh = 0;
      period = 65536;
      integral_acc = 0;
      prev_measured = 0;
      failures = 0;
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Q16.16 product, floored, then saturated.
    function longint qmul(longint a, longint b);
      return clip32((a * b) >>> 16);
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      logic signed [31:0] sdata;
      sdata = data;
      case (idx)
        REG_GAIN_P:    gain_p = sdata;
        REG_GAIN_I:    gain_i = sdata;
        REG_GAIN_D:    gain_d = sdata;
        REG_DRIVE_LIM: drive_lim = longint'(data[30:0]);
        REG_ACC_LIM:   acc_lim = longint'(data[30:0]);
        REG_DEAD_BAND: band_thresh = longint'(data[30:0]);
        REG_PERIOD:    period = longint'(data[30:0]);
        default: ;
      endcase
    endfunction

    function drive_beat_t predict_drive(longint target, longint measured);
      longint err, mag, p_part, integ, i_part, divisor, rate, d_part, sum;
      drive_beat_t res;
      err = clip32(target - measured);
      mag = (err < 0) ? -err : err;
      // The error is dropped only when strictly inside the dead band.
      if (mag < band_thresh) err = 0;
      p_part = qmul(gain_p, err);
      // Integral with anti-windup clamp; a zero period adds nothing.
      integ = clip32(integral_acc + qmul(err, period));
      if (integ > acc_lim) integ = acc_lim;
      else if (integ < -acc_lim) integ = -acc_lim;
      integral_acc = integ;
      i_part = qmul(gain_i, integ);
      // Derivative on the measurement; the divider sees a zero period as one LSB.
      divisor = (period > 0) ? period : 1;
      rate = clip32(((measured - prev_measured) * 64'sd65536) / divisor);
      d_part = clip32(-((gain_d * rate) >>> 16));
      prev_measured = measured;
      sum = p_part + i_part + d_part;
      res.clamped = 1'b0;
      if (sum > drive_lim) begin
        sum = drive_lim;
        res.clamped = 1'b1;
      end else if (sum < -drive_lim) begin
        sum = -drive_lim;
        res.clamped = 1'b1;
      end
      res.drive = sum[31:0];
      return res;
    endfunction

    function void note_setpoint_beat(logic signed [31:0] target, logic signed [31:0] measured);
      expected_drives.push_back(predict_drive(target, measured));
    endfunction

    function void check_drive_beat(logic [31:0] drive, logic clamped);
      drive_beat_t want;
      if (expected_drives.size() == 0) begin
        $display("%0t: unexpected drive beat: expected none actual %h clamp %b",
                 $time, drive, clamped);
        failures++;
        return;
      end
      want = expected_drives.pop_front();
      if (drive !== want.drive) begin
        $display("%0t: drive_value mismatch: expected %h actual %h", $time, want.drive, drive);
        failures++;
      end
      if (clamped !== want.clamped) begin
        $display("%0t: drive_clamped mismatch: expected %b actual %b",
                 $time, want.clamped, clamped);
        failures++;
      end
    endfunction

    function int pending();
      return expected_drives.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [63:0]          in_tdata;   // [31:0] target_value, [63:32] measured_value
  logic                 out_tvalid;
  logic                 out_tready;
  logic [31:0]          out_tdata;  // [31:0] drive_value
  logic [0:0]           out_tuser;  // [0] drive_clamped

  drive_scoreboard drive_sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold;
  int idle_cycles;
  logic signed [31:0] set_point;
  logic signed [31:0] plant;

  pid_controller_step_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: a long hold-off takes priority over the random idling.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Result checking and the no-progress watchdog.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      drive_sb.check_drive_beat(out_tdata, out_tuser[0]);
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("pid_controller_step_top regression: fail");
      $finish;
    end
  end

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    drive_sb.write_register(idx, data);
  endtask

  task automatic apply_settings(input logic [31:0] kp, ki, kd, dl, al, db, per);
    write_register(REG_GAIN_P, kp);
    write_register(REG_GAIN_I, ki);
    write_register(REG_GAIN_D, kd);
    write_register(REG_DRIVE_LIM, dl);
    write_register(REG_ACC_LIM, al);
    write_register(REG_DEAD_BAND, db);
    write_register(REG_PERIOD, per);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One setpoint beat, preceded by a random number of idle cycles.
  task automatic send_setpoint(input logic signed [31:0] tgt, input logic signed [31:0] meas);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {meas, tgt};
    do @(posedge clk); while (!in_tready);
    drive_sb.note_setpoint_beat(tgt, meas);
  endtask

  // Stop offering beats and wait until every predicted drive beat has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (drive_sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom();
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  function automatic logic [30:0] pick_limit();
    case ($urandom_range(0, 9))
      0:       return 31'd0;
      1:       return 31'h7FFF_FFFF;
      2:       return 31'($urandom());
      default: return 31'($urandom_range(32'h0001_0000, 32'h0100_0000));
    endcase
  endfunction

  // Random settings; bit 31 of the unsigned registers is noise that must be dropped.
  task automatic apply_random_settings();
    logic [30:0] dl, al, db, per;
    longint twice;
    dl = pick_limit();
    twice = 2 * longint'(dl);
    if ($urandom_range(0, 3) != 0) al = (twice > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : twice[30:0];
    else al = pick_limit();
    case ($urandom_range(0, 7))
      0:       db = 31'd0;
      1:       db = 31'h7FFF_FFFF;
      2:       db = 31'($urandom());
      default: db = 31'($urandom_range(0, 32'h8000));
    endcase
    case ($urandom_range(0, 9))
      0:       per = 31'd1;
      1:       per = 31'h7FFF_FFFF;
      2:       per = 31'($urandom());
      default: per = 31'($urandom_range(32'h100, 32'h0004_0000));
    endcase
    if ($urandom_range(0, 3) == 0) write_register(REG_UNUSED, $urandom());
    apply_settings(pick_gain(), pick_gain(), pick_gain(), {1'($urandom()), dl},
                   {1'($urandom()), al}, {1'($urandom()), db}, {1'($urandom()), per});
  endtask

  // Mostly a plant that follows its setpoint, with some wholly random beats.
  task automatic run_random_items(input int count);
    int k;
    int drift;
    int jitter;
    logic signed [31:0] tgt;
    logic signed [31:0] meas;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) == 0) set_point = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
      case ($urandom_range(0, 9))
        0: begin
          tgt  = $urandom();
          meas = $urandom();
        end
        1: begin
          tgt  = set_point;
          meas = $urandom();
        end
        default: begin
          drift  = (set_point - plant) >>> 3;
          jitter = $urandom_range(0, 32'h4000);
          plant  = plant + drift + jitter - 32'sh2000;
          tgt    = set_point;
          meas   = plant;
        end
      endcase
      send_setpoint(tgt, meas);
    end
  endtask

  initial begin
    int mode;
    int part;
    drive_sb = new();
    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    tx_idle_pct = 20;
    rx_idle_pct = 84;
    rx_hold     = 0;
    idle_cycles = 0;
    set_point   = '0;
    plant       = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Unity proportional gain: clamp edges and the dead band edges.
    apply_settings(Q_ONE, 32'd0, 32'd0, 32'h0005_0000, 32'h000A_0000, Q_ONE, Q_ONE);
    send_setpoint(32'sd0, 32'sd0);
    send_setpoint(32'sh0005_0000, 32'sd0);
    send_setpoint(32'sh0005_0001, 32'sd0);
    send_setpoint(32'sd0, 32'sh0005_0000);
    send_setpoint(32'sd0, 32'sh0005_0001);
    send_setpoint(32'sh0001_0000, 32'sd0);
    send_setpoint(32'sh0000_FFFF, 32'sd0);
    send_setpoint(32'sd0, 32'sh0000_FFFF);
    send_setpoint(32'sh7FFF_FFFF, 32'sh8000_0000);
    send_setpoint(32'sh8000_0000, 32'sh7FFF_FFFF);
    send_setpoint(-32'sd1, -32'sd1);

    // Extreme gains and limits with the shortest period.
    wait_drained();
    apply_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'd0, 32'd1);
    send_setpoint(32'sh7FFF_FFFF, 32'sh8000_0000);
    send_setpoint(32'sh8000_0000, 32'sh7FFF_FFFF);
    send_setpoint(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_setpoint(32'sh8000_0000, 32'sh8000_0000);
    send_setpoint(32'sd1, 32'sd0);

    // Zero limits, widest dead band and a zero period; the unused index is ignored.
    wait_drained();
    write_register(REG_UNUSED, 32'hFFFF_FFFF);
    apply_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0,
                   32'hFFFF_FFFF, 32'h8000_0000);
    send_setpoint(32'sd0, 32'sd0);
    send_setpoint(32'sh7FFF_FFFF, 32'sh8000_0000);
    send_setpoint(32'sh1234_5678, 32'sh9ABC_DEF0);
    send_setpoint(32'sd0, 32'sd1);

    // Zero period with ordinary gains and limits.
    wait_drained();
    apply_settings(Q_ONE, Q_ONE, Q_ONE, 32'h0064_0000, 32'h00C8_0000, 32'd0, 32'd0);
    send_setpoint(32'sh0002_0000, 32'sh0001_0000);
    send_setpoint(-32'sh0003_0000, 32'sh0000_0010);
    send_setpoint(32'sd0, 32'sh7FFF_FFFF);

    // Random part: three idling patterns, each over several settings.
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          tx_idle_pct = 20;
          rx_idle_pct = 84;
        end
        1: begin
          tx_idle_pct = 84;
          rx_idle_pct = 20;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (part = 0; part < 4; part++) begin
        wait_drained();
        apply_random_settings();
        // Long receiver hold-off while beats keep coming, so the input backs up.
        if (mode == 2 && part == 0) rx_hold = 400;
        run_random_items(45);
        // Sender pauses mid-stream until every drive beat has come back.
        if (mode == 0 && part == 1) wait_drained();
        run_random_items(45);
      end
    end

    wait_drained();
    repeat (60) @(posedge clk);
    if (drive_sb.failures == 0 && drive_sb.pending() == 0) begin
      $display("pid_controller_step_top regression: pass");
    end else begin
      $display("pid_controller_step_top regression: fail");
    end
    $finish;
  end

endmodule

### pid_controller_step_top.f
rtl/pid_pkg.sv
rtl/pid_mul.sv
rtl/pid_div.sv
rtl/pid_controller_step_top.sv
tb/tb_pid_controller_step_top.sv
